FILE: hw/rtl/swa_pkg.sv
package swa_pkg;

    // window and sample geometry
    localparam int WINDOW_MAX  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int PTR_W       = $clog2(WINDOW_MAX);
    localparam int CNT_W       = 5;

    // accumulator and result widths
    localparam int SUM_W  = 21;
    localparam int WSUM_W = 24;
    localparam int OUT_W  = 24;
    localparam int FRAC_W = 8;

    // serial divider: 32-bit dividend magnitude, 8-bit divisor, two quotient bits a cycle
    localparam int DVD_W     = 32;
    localparam int DIV_W     = 8;
    localparam int BITS_STEP = 2;
    localparam int DIV_STEPS = DVD_W / BITS_STEP;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // product of a sample and a tap weight (weight is unsigned, one bit wider when signed)
    localparam int PROD_W = SAMPLE_BITS + CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_OUTPUT
    } state_t;

    typedef enum logic {
        DIV_PLAIN,
        DIV_WEIGHTED
    } div_sel_t;

endpackage

FILE: hw/rtl/sliding_window_average.sv
// sliding_window_average: simple and linearly weighted moving average of the last
// window_size signed samples (window_size 0 acts as 1, values above 16 act as 16).
// each accepted word produces exactly one result word carrying the plain mean, the
// weighted mean (oldest held sample weight 1, newest weight held_count) and the number
// of held samples; both means have 8 fraction bits and truncate toward zero. while the
// window fills only the samples taken so far count; shrinking the window drops the
// oldest samples at once. the sample is stored at the accepting edge; the shared
// multiply-accumulate then walks the window store, then two passes go through the
// one shared radix-4 divider (plain mean by held_count, weighted mean by the weight
// sum), and the output register is loaded as soon as it is free. in_stall is high
// from acceptance until that load, so a new word is taken only once the previous one
// is through; a finished result waits in the output register, so the next word is
// taken while the previous result is still stalled downstream.
// window_size may be written only while the block is idle.
module sliding_window_average
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [swa_pkg::CNT_W-1:0]           cfg_wr_data,
    // sample channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [swa_pkg::SAMPLE_BITS-1:0] sample,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [swa_pkg::OUT_W-1:0]    plain_mean,
    output logic signed [swa_pkg::OUT_W-1:0]    weighted_mean,
    output logic [swa_pkg::CNT_W-1:0]           held_count
);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------

    // control
    swa_pkg::state_t                  state_reg, state_next;
    swa_pkg::div_sel_t                div_sel_reg, div_sel_next;
    logic [swa_pkg::CNT_W-1:0]        window_size_reg, window_size_next;
    logic [swa_pkg::CNT_W-1:0]        fill_count_reg, fill_count_next;
    logic [swa_pkg::PTR_W-1:0]        write_pointer_reg, write_pointer_next;
    logic [swa_pkg::PTR_W-1:0]        tap_reg, tap_next;
    logic [swa_pkg::STEP_W-1:0]       step_reg, step_next;
    logic                             out_valid_reg, out_valid_next;

    // window store, no reset: only written entries are ever read
    logic signed [swa_pkg::SAMPLE_BITS-1:0] window_store_reg [swa_pkg::WINDOW_MAX];

    // datapath
    logic [swa_pkg::PTR_W-1:0]              read_pos_reg, read_pos_next;
    logic signed [swa_pkg::SUM_W-1:0]       running_sum_reg, running_sum_next;
    logic signed [swa_pkg::WSUM_W-1:0]      running_wsum_reg, running_wsum_next;
    logic [swa_pkg::DVD_W-1:0]              dvd_reg, dvd_next;
    logic [swa_pkg::DIV_W-1:0]              rem_reg, rem_next;
    logic [swa_pkg::DIV_W-1:0]              divisor_reg, divisor_next;
    logic                                   neg_reg, neg_next;
    logic signed [swa_pkg::OUT_W-1:0]       plain_res_reg, plain_res_next;
    logic signed [swa_pkg::OUT_W-1:0]       out_plain_reg, out_plain_next;
    logic signed [swa_pkg::OUT_W-1:0]       out_weighted_reg, out_weighted_next;
    logic [swa_pkg::CNT_W-1:0]              out_count_reg, out_count_next;

    // ------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------

    logic                             in_accept;
    logic                             out_free;
    logic [swa_pkg::CNT_W-1:0]        eff_size;
    logic [swa_pkg::CNT_W-1:0]        fill_inc;
    logic [swa_pkg::CNT_W-1:0]        new_count;
    logic                             accum_last;

    // multiply-accumulate
    logic signed [swa_pkg::SAMPLE_BITS-1:0] tap_sample;
    logic [swa_pkg::CNT_W-1:0]              tap_weight;
    logic signed [swa_pkg::PROD_W-1:0]      tap_prod;

    // divider operands
    logic [swa_pkg::SUM_W-1:0]        sum_abs;
    logic [swa_pkg::WSUM_W-1:0]       wsum_abs;
    logic [swa_pkg::CNT_W:0]          count_plus;
    logic [2*swa_pkg::CNT_W+1:0]      weight_total_x2;
    logic [swa_pkg::DVD_W-1:0]        dvd_step;
    logic [swa_pkg::DIV_W-1:0]        rem_step;
    logic [swa_pkg::DVD_W-1:0]        quot_signed;

    assign in_accept = in_valid && (state_reg == swa_pkg::ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // clamp the configured size into 1..WINDOW_MAX
    always_comb
    begin
        if (window_size_reg == '0)
            eff_size = swa_pkg::CNT_W'(1);
        else if (window_size_reg > swa_pkg::CNT_W'(swa_pkg::WINDOW_MAX))
            eff_size = swa_pkg::CNT_W'(swa_pkg::WINDOW_MAX);
        else
            eff_size = window_size_reg;
    end

    assign fill_inc  = fill_count_reg + swa_pkg::CNT_W'(1);
    assign new_count = (fill_inc > eff_size) ? eff_size : fill_inc;

    // tap_reg counts from the oldest held sample, weight is tap + 1
    assign accum_last = ({1'b0, tap_reg} == (fill_count_reg - swa_pkg::CNT_W'(1)));
    assign tap_sample = window_store_reg[read_pos_reg];
    assign tap_weight = {1'b0, tap_reg} + swa_pkg::CNT_W'(1);
    assign tap_prod   = swa_pkg::PROD_W'(tap_sample)
                      * swa_pkg::PROD_W'($signed({1'b0, tap_weight}));

    // magnitudes for the unsigned divider
    assign sum_abs  = running_sum_reg[swa_pkg::SUM_W-1]
                    ? (~running_sum_reg + swa_pkg::SUM_W'(1)) : running_sum_reg;
    assign wsum_abs = running_wsum_reg[swa_pkg::WSUM_W-1]
                    ? (~running_wsum_reg + swa_pkg::WSUM_W'(1)) : running_wsum_reg;

    // weight sum n*(n+1)/2
    assign count_plus      = {1'b0, fill_count_reg} + (swa_pkg::CNT_W+1)'(1);
    assign weight_total_x2 = {{(swa_pkg::CNT_W+2){1'b0}}, fill_count_reg}
                           * {{(swa_pkg::CNT_W+1){1'b0}}, count_plus};

    // radix-4 restoring divide step: quotient bits shift in at the bottom of dvd
    always_comb
    begin
        logic [swa_pkg::DIV_W:0] trial;
        logic [swa_pkg::DIV_W:0] diff;
        dvd_step = dvd_reg;
        rem_step = rem_reg;
        for (int i = 0; i < swa_pkg::BITS_STEP; i++)
        begin
            trial    = {rem_step, dvd_step[swa_pkg::DVD_W-1]};
            diff     = trial - {1'b0, divisor_reg};
            dvd_step = {dvd_step[swa_pkg::DVD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_step    = diff[swa_pkg::DIV_W-1:0];
                dvd_step[0] = 1'b1;
            end
            else
            begin
                rem_step = trial[swa_pkg::DIV_W-1:0];
            end
        end
    end

    // restore the sign, the result wraps to the output width
    assign quot_signed = neg_reg ? (~dvd_reg + swa_pkg::DVD_W'(1)) : dvd_reg;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------

    always_comb
    begin
        state_next         = state_reg;
        div_sel_next       = div_sel_reg;
        window_size_next   = window_size_reg;
        fill_count_next    = fill_count_reg;
        write_pointer_next = write_pointer_reg;
        tap_next           = tap_reg;
        step_next          = step_reg;
        out_valid_next     = out_valid_reg && out_stall;
        read_pos_next      = read_pos_reg;
        running_sum_next   = running_sum_reg;
        running_wsum_next  = running_wsum_reg;
        dvd_next           = dvd_reg;
        rem_next           = rem_reg;
        divisor_next       = divisor_reg;
        neg_next           = neg_reg;
        plain_res_next     = plain_res_reg;
        out_plain_next     = out_plain_reg;
        out_weighted_next  = out_weighted_reg;
        out_count_next     = out_count_reg;

        if (cfg_wr_en)
            window_size_next = cfg_wr_data;

        case (state_reg)
            swa_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    // sample goes into the store in the sequential block below
                    write_pointer_next = write_pointer_reg + swa_pkg::PTR_W'(1);
                    fill_count_next    = new_count;
                    // oldest held sample sits new_count entries behind the new pointer
                    read_pos_next      = write_pointer_reg + swa_pkg::PTR_W'(1)
                                       - new_count[swa_pkg::PTR_W-1:0];
                    tap_next           = '0;
                    running_sum_next   = '0;
                    running_wsum_next  = '0;
                    state_next         = swa_pkg::ST_ACCUM;
                end
            end

            swa_pkg::ST_ACCUM:
            begin
                running_sum_next  = running_sum_reg
                                  + swa_pkg::SUM_W'(tap_sample);
                running_wsum_next = running_wsum_reg
                                  + swa_pkg::WSUM_W'(tap_prod);
                read_pos_next     = read_pos_reg + swa_pkg::PTR_W'(1);
                tap_next          = tap_reg + swa_pkg::PTR_W'(1);
                if (accum_last)
                begin
                    div_sel_next = swa_pkg::DIV_PLAIN;
                    state_next   = swa_pkg::ST_DIV_LOAD;
                end
            end

            swa_pkg::ST_DIV_LOAD:
            begin
                rem_next  = '0;
                step_next = '0;
                if (div_sel_reg == swa_pkg::DIV_PLAIN)
                begin
                    dvd_next     = {{(swa_pkg::DVD_W-swa_pkg::SUM_W-swa_pkg::FRAC_W){1'b0}},
                                    sum_abs, {swa_pkg::FRAC_W{1'b0}}};
                    divisor_next = swa_pkg::DIV_W'(fill_count_reg);
                    neg_next     = running_sum_reg[swa_pkg::SUM_W-1];
                end
                else
                begin
                    dvd_next     = swa_pkg::DVD_W'({wsum_abs, {swa_pkg::FRAC_W{1'b0}}});
                    divisor_next = weight_total_x2[swa_pkg::DIV_W:1];
                    neg_next     = running_wsum_reg[swa_pkg::WSUM_W-1];
                end
                state_next = swa_pkg::ST_DIV_RUN;
            end

            swa_pkg::ST_DIV_RUN:
            begin
                dvd_next  = dvd_step;
                rem_next  = rem_step;
                step_next = step_reg + swa_pkg::STEP_W'(1);
                if (step_reg == swa_pkg::STEP_W'(swa_pkg::DIV_STEPS - 1))
                    state_next = swa_pkg::ST_DIV_STORE;
            end

            swa_pkg::ST_DIV_STORE:
            begin
                if (div_sel_reg == swa_pkg::DIV_PLAIN)
                begin
                    plain_res_next = quot_signed[swa_pkg::OUT_W-1:0];
                    div_sel_next   = swa_pkg::DIV_WEIGHTED;
                    state_next     = swa_pkg::ST_DIV_LOAD;
                end
                else
                begin
                    // keep the weighted quotient in dvd until the output register is free
                    dvd_next   = quot_signed;
                    neg_next   = 1'b0;
                    state_next = swa_pkg::ST_OUTPUT;
                end
            end

            swa_pkg::ST_OUTPUT:
            begin
                if (out_free)
                begin
                    out_plain_next    = plain_res_reg;
                    out_weighted_next = dvd_reg[swa_pkg::OUT_W-1:0];
                    out_count_next    = fill_count_reg;
                    out_valid_next    = 1'b1;
                    state_next        = swa_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = swa_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= swa_pkg::ST_IDLE;
            div_sel_reg       <= swa_pkg::DIV_PLAIN;
            window_size_reg   <= swa_pkg::CNT_W'(swa_pkg::WINDOW_MAX);
            fill_count_reg    <= '0;
            write_pointer_reg <= '0;
            tap_reg           <= '0;
            step_reg          <= '0;
            out_valid_reg     <= 1'b0;
            running_sum_reg   <= '0;
            running_wsum_reg  <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            div_sel_reg       <= div_sel_next;
            window_size_reg   <= window_size_next;
            fill_count_reg    <= fill_count_next;
            write_pointer_reg <= write_pointer_next;
            tap_reg           <= tap_next;
            step_reg          <= step_next;
            out_valid_reg     <= out_valid_next;
            running_sum_reg   <= running_sum_next;
            running_wsum_reg  <= running_wsum_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        read_pos_reg     <= read_pos_next;
        dvd_reg          <= dvd_next;
        rem_reg          <= rem_next;
        divisor_reg      <= divisor_next;
        neg_reg          <= neg_next;
        plain_res_reg    <= plain_res_next;
        out_plain_reg    <= out_plain_next;
        out_weighted_reg <= out_weighted_next;
        out_count_reg    <= out_count_next;
    end

    // window store write port
    always_ff @(posedge clk)
    begin
        if (in_accept)
            window_store_reg[write_pointer_reg] <= sample;
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------

    assign in_stall      = (state_reg != swa_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign plain_mean    = out_plain_reg;
    assign weighted_mean = out_weighted_reg;
    assign held_count    = out_count_reg;

endmodule
